// ===== rtl/core/sacia_pkg.sv =====
// shared types, status and control bit positions for the serial adapter register block
package sacia_pkg;

    // item kinds carried in s_axis_tuser
    typedef enum logic [1:0] {
        FUNC_BUS_READ  = 2'd0,
        FUNC_BUS_WRITE = 2'd1,
        FUNC_RX_BYTE   = 2'd2,
        FUNC_TX_SLOT   = 2'd3
    } t_func;

    // register select
    localparam logic SEL_CTRL_STATUS = 1'b0;
    localparam logic SEL_DATA        = 1'b1;

    // status bits
    localparam logic [7:0] RDRF_BM = 8'h01;
    localparam logic [7:0] TDRE_BM = 8'h02;
    localparam logic [7:0] DCD_BM  = 8'h04;
    localparam logic [7:0] OVRN_BM = 8'h20;
    localparam logic [7:0] IRQF_BM = 8'h80;

    // control bits
    localparam logic [7:0] CDS_DIV_BY_ONE = 8'h00;
    localparam logic [7:0] CDS_MASK       = 8'h03;
    localparam logic [7:0] CDS_RESET      = 8'h03;
    localparam logic [7:0] TCB_MASK       = 8'h60;
    localparam logic [7:0] TCB_TXIE       = 8'h20;
    localparam logic [7:0] RIE_BM         = 8'h80;

    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 24;

    typedef struct packed {
        logic [7:0] control;
        logic [7:0] status;
        logic [7:0] flags_to_clear;
        logic [7:0] flags_pending;
        logic [7:0] tx_hold;
        logic [7:0] rx_hold;
        logic       rx_irq;
        logic       tx_irq;
    } t_regs;

    typedef struct packed {
        t_func      func;
        logic       reg_select;
        logic [7:0] wdata;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_rx;
        logic       irq_tx;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } t_result;

endpackage

// ===== rtl/core/sacia_update.sv =====
// next register state and result for one item
module sacia_update (
    input  sacia_pkg::t_regs   i_regs,
    input  sacia_pkg::t_item   i_item,
    output sacia_pkg::t_regs   o_regs,
    output sacia_pkg::t_result o_result
);
    import sacia_pkg::*;

    logic [7:0] w_delta;
    logic       w_txie;
    logic       w_rie;
    logic [7:0] w_stat_in;

    // status with irq flag following both lines
    assign w_stat_in = (i_regs.status & ~IRQF_BM) |
                       ((i_regs.rx_irq | i_regs.tx_irq) ? IRQF_BM : 8'h00);
    assign w_txie    = (i_regs.control & TCB_MASK) == TCB_TXIE;
    assign w_rie     = (i_regs.control & RIE_BM) != 8'h00;
    assign w_delta   = i_regs.control ^ i_item.wdata;

    always_comb begin
        t_regs   r;
        t_result q;
        r        = i_regs;
        r.status = w_stat_in;
        q        = '0;
        case (i_item.func)
            FUNC_BUS_READ: begin
                if (i_item.reg_select == SEL_CTRL_STATUS) begin
                    r.flags_to_clear = w_stat_in & (DCD_BM | OVRN_BM);
                    q.rdata          = w_stat_in;
                end else begin
                    r.status = (w_stat_in & ~(RDRF_BM | i_regs.flags_to_clear))
                               | i_regs.flags_pending;
                    r.flags_to_clear = 8'h00;
                    r.flags_pending  = 8'h00;
                    if (w_rie) begin
                        r.rx_irq = (r.status & (RDRF_BM | OVRN_BM)) != 8'h00;
                    end
                    q.rdata = i_regs.rx_hold;
                end
            end
            FUNC_BUS_WRITE: begin
                if (i_item.reg_select == SEL_CTRL_STATUS) begin
                    r.control = i_item.wdata;
                    // master reset on a change into counter select three
                    if ((w_delta & CDS_MASK) != 8'h00 &&
                        (i_item.wdata & CDS_MASK) == CDS_RESET) begin
                        r.rx_irq         = 1'b0;
                        r.tx_irq         = 1'b0;
                        r.status         = TDRE_BM;
                        r.flags_to_clear = 8'h00;
                        r.flags_pending  = 8'h00;
                    end
                    if ((w_delta & TCB_MASK) != 8'h00) begin
                        r.tx_irq = ((i_item.wdata & TCB_MASK) == TCB_TXIE) &&
                                   ((r.status & TDRE_BM) != 8'h00);
                    end
                    if ((w_delta & RIE_BM) != 8'h00) begin
                        r.rx_irq = ((i_item.wdata & RIE_BM) != 8'h00) &&
                                   ((r.status & RDRF_BM) != 8'h00);
                    end
                end else begin
                    r.tx_hold = i_item.wdata;
                    r.status  = w_stat_in & ~TDRE_BM;
                    if (w_txie) begin
                        r.tx_irq = 1'b0;
                    end
                end
            end
            FUNC_RX_BYTE: begin
                r.rx_hold = i_item.rx_byte;
                if ((w_stat_in & RDRF_BM) != 8'h00) begin
                    r.flags_pending = i_regs.flags_pending | OVRN_BM;
                end
                r.status = w_stat_in | RDRF_BM;
                if (w_rie) begin
                    r.rx_irq = 1'b1;
                end
            end
            FUNC_TX_SLOT: begin
                if ((w_stat_in & TDRE_BM) == 8'h00) begin
                    q.tx_valid = 1'b1;
                    q.tx_byte  = i_regs.tx_hold;
                    r.status   = w_stat_in | TDRE_BM;
                    if (w_txie) begin
                        r.tx_irq = 1'b1;
                    end
                end
            end
            default: begin
                r = i_regs;
            end
        endcase
        r.status = (r.status & ~IRQF_BM) | ((r.rx_irq | r.tx_irq) ? IRQF_BM : 8'h00);
        q.irq_rx = r.rx_irq;
        q.irq_tx = r.tx_irq;
        o_regs   = r;
        o_result = q;
    end

endmodule

// ===== rtl/core/serial_acia_registers_unit.sv =====
// serial adapter register block: control/status and data registers with serial events
// Each item is a bus read, a bus write, a received byte or a free transmit slot, and each
// gives exactly one result. The block takes one item per clock while s_axis_tready is high; an
// input register holds the item, and one pass of register update logic then loads the new
// register state and the result register once that register is free or draining. The
// input side stays ready while a result waits, as long as the held item can move on, so a
// stalled output costs at most one extra item of buffering before s_axis_tready drops.
module serial_acia_registers_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // wdata [7:0], rx_byte [15:8]
    input  logic [sacia_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func [1:0], reg_select [2]
    input  logic [sacia_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // rdata [7:0], irq_rx [8], irq_tx [9], tx_valid [10], tx_byte [18:11], zero [23:19]
    output logic [sacia_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sacia_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_regs   r_regs;
    t_regs   n_regs;
    t_result n_result;
    logic    w_advance;

    // held item moves to the result register when that one is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    sacia_update u_update (
        .i_regs   (r_regs),
        .i_item   (r_item),
        .o_regs   (n_regs),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.func       <= t_func'(s_axis_tuser[1:0]);
            r_item.reg_select <= s_axis_tuser[2];
            r_item.wdata      <= s_axis_tdata[7:0];
            r_item.rx_byte    <= s_axis_tdata[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.control        <= CDS_DIV_BY_ONE;
            r_regs.status         <= TDRE_BM;
            r_regs.flags_to_clear <= 8'h00;
            r_regs.flags_pending  <= 8'h00;
            r_regs.tx_hold        <= 8'h00;
            r_regs.rx_hold        <= 8'h00;
            r_regs.rx_irq         <= 1'b0;
            r_regs.tx_irq         <= 1'b0;
        end else if (w_advance) begin
            r_regs <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_result.tx_byte, r_result.tx_valid,
                            r_result.irq_tx, r_result.irq_rx, r_result.rdata};

endmodule

// ===== rtl/core/sacia_checker.sv =====
// port-level checks for the serial adapter register block, bound to the top level
module sacia_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [sacia_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [sacia_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sacia_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import sacia_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // with no result waiting the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // no byte leaves without its send flag, padding stays zero
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[10] |-> m_axis_tdata[18:11] == 8'h00 &&
        m_axis_tdata[23:19] == 5'b0)
        else $error("transmit byte without send flag");

    // input stalls only while a result is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind serial_acia_registers_unit sacia_checker u_sacia_checker (.*);
